@@ design/alarm_panel_state_machine_defines.svh @@
// Assertion macros used by the alarm panel state machine design file
`ifndef ALARM_PANEL_STATE_MACHINE_DEFINES_SVH
`define ALARM_PANEL_STATE_MACHINE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during rst
`define APSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst
`define APSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/apsm_pkg.sv @@
// Shared types, codes and a helper function for the alarm panel controller
package apsm_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_ALARM = 2'd1;
  localparam logic [1:0] REQ_MODE  = 2'd2;

  // Arm modes
  localparam logic [1:0] MODE_DISARMED = 2'd0;
  localparam logic [1:0] MODE_STAY     = 2'd1;
  localparam logic [1:0] MODE_NIGHT    = 2'd2;
  localparam logic [1:0] MODE_AWAY     = 2'd3;

  // Panel status codes
  localparam logic [3:0] ST_DISARMED = 4'd0;
  localparam logic [3:0] ST_EXIT     = 4'd4;
  localparam logic [3:0] ST_ENTRY    = 4'd5;
  localparam logic [3:0] ST_ALARM    = 4'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_ID      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAYS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAYS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DURATIONS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_STAY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_NIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_AWAY      = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_SYSTEM_ID      = 8'd1;
  localparam logic [31:0] RST_EXIT_DELAYS    = 32'h7878_7800;
  localparam logic [31:0] RST_ENTRY_DELAYS   = 32'h7878_7800;
  localparam logic [23:0] RST_TRIG_DURATIONS = 24'h78_7878;
  localparam logic [15:0] RST_ARM_MASK       = 16'hFF00;

  localparam logic [8:0] ELAPSED_MAX = 9'h1FF;

  typedef struct packed {
    logic [7:0]  system_id;
    logic [31:0] exit_delays;
    logic [31:0] entry_delays;
    logic [23:0] trigger_durations;
    logic [15:0] arm_mask_stay;
    logic [15:0] arm_mask_night;
    logic [15:0] arm_mask_away;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] alarm_word;
    logic [1:0]  new_mode;
  } item_t;

  typedef struct packed {
    logic [3:0] panel_status;
    logic [7:0] seconds_remaining;
    logic       status_changed;
  } res_t;

  // Pick one byte of a 32-bit word
  function automatic logic [7:0] byte_sel(input logic [31:0] word, input logic [1:0] idx);
    logic [31:0] sh;
    sh = word >> {idx, 3'b000};
    return sh[7:0];
  endfunction

endpackage

@@ design/apsm_cfg.sv @@
// Configuration register file of the alarm panel controller
module apsm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [apsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output apsm_pkg::cfg_t                 cfg
);
  import apsm_pkg::*;

  // Load a register on each write; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.system_id         <= RST_SYSTEM_ID;
      cfg.exit_delays       <= RST_EXIT_DELAYS;
      cfg.entry_delays      <= RST_ENTRY_DELAYS;
      cfg.trigger_durations <= RST_TRIG_DURATIONS;
      cfg.arm_mask_stay     <= RST_ARM_MASK;
      cfg.arm_mask_night    <= RST_ARM_MASK;
      cfg.arm_mask_away     <= RST_ARM_MASK;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYSTEM_ID:      cfg.system_id         <= cfg_data[7:0];
        CFG_EXIT_DELAYS:    cfg.exit_delays       <= cfg_data;
        CFG_ENTRY_DELAYS:   cfg.entry_delays      <= cfg_data;
        CFG_TRIG_DURATIONS: cfg.trigger_durations <= cfg_data[23:0];
        CFG_MASK_STAY:      cfg.arm_mask_stay     <= cfg_data[15:0];
        CFG_MASK_NIGHT:     cfg.arm_mask_night    <= cfg_data[15:0];
        CFG_MASK_AWAY:      cfg.arm_mask_away     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/apsm_fsm.sv @@
// Panel phase state machine with countdown and status tracking
`include "alarm_panel_state_machine_defines.svh"

module apsm_fsm (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  apsm_pkg::item_t item,
  input  apsm_pkg::cfg_t  cfg,
  output apsm_pkg::res_t  res
);
  import apsm_pkg::*;

  typedef enum logic [2:0] {
    PH_DISARMED,
    PH_EXIT,
    PH_ARMING,
    PH_ARMED,
    PH_ENTRY,
    PH_ALARM
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  target_mode, target_mode_next;
  logic [8:0]  elapsed, elapsed_next;
  logic [7:0]  remaining, remaining_next;
  logic [3:0]  last_status;

  logic [8:0]  elapsed_inc;
  logic [7:0]  exit_dly;
  logic [7:0]  entry_dly;
  logic [7:0]  trig_dur;
  logic [15:0] arm_mask;
  logic [8:0]  exit_left;
  logic [8:0]  entry_left;
  logic        alarm_hit;
  logic [3:0]  status;

  // Per-mode timing and mask selection
  always_comb begin
    exit_dly  = byte_sel(cfg.exit_delays, target_mode);
    entry_dly = byte_sel(cfg.entry_delays, target_mode);
    trig_dur  = (target_mode == MODE_DISARMED) ? 8'd0
              : byte_sel({8'd0, cfg.trigger_durations}, target_mode - 2'd1);
    case (target_mode)
      MODE_STAY:  arm_mask = cfg.arm_mask_stay;
      MODE_NIGHT: arm_mask = cfg.arm_mask_night;
      MODE_AWAY:  arm_mask = cfg.arm_mask_away;
      default:    arm_mask = '0;
    endcase
  end

  // Saturating elapsed counter and time left on each countdown
  assign elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 9'd1;
  assign exit_left   = {1'b0, exit_dly} - elapsed_inc;
  assign entry_left  = {1'b0, entry_dly} - elapsed_inc;
  assign alarm_hit   = ((item.alarm_word[15:0] & arm_mask) != 16'd0)
                    && (item.alarm_word[7:0] == cfg.system_id);

  // Next phase for the item in hand
  always_comb begin
    phase_next       = phase;
    target_mode_next = target_mode;
    elapsed_next     = elapsed;
    remaining_next   = remaining;
    case (item.req_type)
      REQ_TICK: begin
        unique case (phase)
          PH_EXIT: begin
            if (elapsed_inc >= {1'b0, exit_dly}) begin
              elapsed_next   = '0;
              remaining_next = '0;
              phase_next     = (target_mode == MODE_DISARMED) ? PH_DISARMED : PH_ARMING;
            end else begin
              elapsed_next   = elapsed_inc;
              remaining_next = exit_left[7:0];
            end
          end
          PH_ENTRY: begin
            if (elapsed_inc >= {1'b0, entry_dly}) begin
              elapsed_next   = '0;
              remaining_next = '0;
              phase_next     = PH_ALARM;
            end else begin
              elapsed_next   = elapsed_inc;
              remaining_next = entry_left[7:0];
            end
          end
          PH_ALARM: begin
            if (elapsed_inc >= {1'b0, trig_dur}) begin
              elapsed_next = '0;
              phase_next   = PH_ARMED;
            end else begin
              elapsed_next = elapsed_inc;
            end
          end
          PH_ARMING: begin
            elapsed_next = '0;
            phase_next   = PH_ARMED;
          end
          default: begin
          end
        endcase
      end
      REQ_ALARM: begin
        if (phase == PH_ARMED && alarm_hit) begin
          remaining_next = entry_dly;
          elapsed_next   = '0;
          phase_next     = PH_ENTRY;
        end
      end
      REQ_MODE: begin
        if (item.new_mode != target_mode) begin
          target_mode_next = item.new_mode;
          remaining_next   = byte_sel(cfg.exit_delays, item.new_mode);
          elapsed_next     = '0;
          phase_next       = PH_EXIT;
        end
      end
      default: begin
      end
    endcase
  end

  // Status seen after this item
  always_comb begin
    unique case (phase_next)
      PH_EXIT:   status = ST_EXIT;
      PH_ENTRY:  status = ST_ENTRY;
      PH_ALARM:  status = ST_ALARM;
      PH_ARMED:  status = {2'b00, target_mode_next};
      PH_ARMING: status = (target_mode_next == MODE_DISARMED) ? ST_DISARMED
                        : ST_ALARM + {2'b00, target_mode_next};
      default:   status = ST_DISARMED;
    endcase
    res.panel_status      = status;
    res.seconds_remaining = (phase_next == PH_EXIT || phase_next == PH_ENTRY)
                          ? remaining_next : 8'd0;
    res.status_changed    = (status != last_status);
  end

  // Hold state; advance on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_DISARMED;
      target_mode <= MODE_DISARMED;
      elapsed     <= '0;
      remaining   <= '0;
      last_status <= ST_DISARMED;
    end else if (step) begin
      phase       <= phase_next;
      target_mode <= target_mode_next;
      elapsed     <= elapsed_next;
      remaining   <= remaining_next;
      last_status <= status;
    end
  end

  `APSM_ASSERT_NOW(a_disarmed_no_target, phase == PH_DISARMED,
    target_mode == MODE_DISARMED, "disarmed with a target mode set")
  `APSM_ASSERT_NOW(a_armed_has_target,
    phase == PH_ARMED || phase == PH_ARMING || phase == PH_ENTRY || phase == PH_ALARM,
    target_mode != MODE_DISARMED, "armed phase without a target mode")
  `APSM_ASSERT_NEXT(a_idle_holds, !step,
    $stable(phase) && $stable(elapsed) && $stable(last_status), "state moved without an item")
  `APSM_ASSERT_NEXT(a_arming_one_tick, step && item.req_type == REQ_TICK && phase == PH_ARMING,
    phase == PH_ARMED, "arming lasted more than one tick")

endmodule

@@ design/alarm_panel_state_machine.sv @@
// Alarm panel controller: one result item per request item, one item per clock cycle while
// the output is not stalled. Requests (tick, device alarm word, mode change) arrive on the
// s_ side; each gives one status item on the m_ side after passing through the input
// register and then the output register, which the phase logic loads as it updates state.
// A new item is taken every cycle while the output is free or being taken. Configuration
// writes are taken at any time (cfg_ready is always high) and must only occur while no item
// is in flight.
module alarm_panel_state_machine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [39:0]                    s_tdata,  // alarm_word[31:0], new_mode[33:32], zero
  input  logic [1:0]                     s_tuser,  // req_type[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,  // panel_status[3:0],
                                                   // seconds_remaining[11:4],
                                                   // status_changed[12], zero
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import apsm_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  res_t  res;
  res_t  out_res;
  logic  out_free;
  logic  step;

  assign cfg_ready = 1'b1;

  apsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance when the output register can take the result
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type   <= s_tuser;
      in_item.alarm_word <= s_tdata[31:0];
      in_item.new_mode   <= s_tdata[33:32];
    end
  end

  apsm_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.status_changed, out_res.seconds_remaining,
                    out_res.panel_status};

endmodule

@@ test/tb.sv @@
// Testbench for the alarm panel controller: directed and random request streams
`timescale 1ns / 1ps

module tb;
  import apsm_pkg::*;

  // Codes the package leaves out: the unused request kind and register index
  localparam logic [1:0]           REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    PANEL_DISARMED,
    PANEL_EXIT,
    PANEL_ARMING,
    PANEL_ARMED,
    PANEL_ENTRY,
    PANEL_ALARM
  } panel_phase_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;   // alarm_word[31:0], new_mode[33:32], zero
  logic [1:0]           s_tuser = '0;   // req_type[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;        // panel_status[3:0], seconds_remaining[11:4],
                                        // status_changed[12], zero
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Predicted panel state and register copies
  cfg_t         panel_cfg;
  panel_phase_t panel_phase;
  logic [1:0]   panel_target;
  logic [8:0]   panel_elapsed;
  logic [7:0]   panel_remaining;
  logic [3:0]   panel_last_status;

  res_t status_q[$];
  int   error_count = 0;
  bit   tx_gaps_on = 1'b0;
  bit   rx_stalls_on = 1'b0;
  int   rx_hold = 0;

  alarm_panel_state_machine i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror one register write into the predictor
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_SYSTEM_ID:      panel_cfg.system_id = data[7:0];
      CFG_EXIT_DELAYS:    panel_cfg.exit_delays = data;
      CFG_ENTRY_DELAYS:   panel_cfg.entry_delays = data;
      CFG_TRIG_DURATIONS: panel_cfg.trigger_durations = data[23:0];
      CFG_MASK_STAY:      panel_cfg.arm_mask_stay = data[15:0];
      CFG_MASK_NIGHT:     panel_cfg.arm_mask_night = data[15:0];
      CFG_MASK_AWAY:      panel_cfg.arm_mask_away = data[15:0];
      default: ;
    endcase
  endfunction

  // Advance a countdown by one tick; returns 1 once it has run out
  function automatic bit countdown_tick(input logic [7:0] delay);
    if (panel_elapsed != ELAPSED_MAX) panel_elapsed = panel_elapsed + 9'd1;
    if (panel_elapsed >= {1'b0, delay}) begin
      panel_remaining = '0;
      return 1'b1;
    end
    panel_remaining = delay - panel_elapsed[7:0];
    return 1'b0;
  endfunction

  // Update the predicted panel for one accepted request and queue its status item
  function automatic void advance_panel(input item_t it);
    logic [15:0] mask;
    logic [7:0]  trig;
    logic [3:0]  status;
    res_t        r;
    case (it.req_type)
      REQ_TICK: begin
        case (panel_phase)
          PANEL_EXIT: begin
            if (countdown_tick(panel_cfg.exit_delays[{panel_target, 3'b000} +: 8])) begin
              panel_elapsed = '0;
              panel_phase = (panel_target == MODE_DISARMED) ? PANEL_DISARMED : PANEL_ARMING;
            end
          end
          PANEL_ENTRY: begin
            if (countdown_tick(panel_cfg.entry_delays[{panel_target, 3'b000} +: 8])) begin
              panel_elapsed = '0;
              panel_phase = PANEL_ALARM;
            end
          end
          PANEL_ALARM: begin
            trig = (panel_target == MODE_DISARMED) ? 8'd0 :
                   panel_cfg.trigger_durations[{panel_target - 2'd1, 3'b000} +: 8];
            if (panel_elapsed != ELAPSED_MAX) panel_elapsed = panel_elapsed + 9'd1;
            if (panel_elapsed >= {1'b0, trig}) begin
              panel_elapsed = '0;
              panel_phase = PANEL_ARMED;
            end
          end
          PANEL_ARMING: begin
            panel_elapsed = '0;
            panel_phase = PANEL_ARMED;
          end
          default: ;
        endcase
      end
      REQ_ALARM: begin
        case (panel_target)
          MODE_STAY:  mask = panel_cfg.arm_mask_stay;
          MODE_NIGHT: mask = panel_cfg.arm_mask_night;
          MODE_AWAY:  mask = panel_cfg.arm_mask_away;
          default:    mask = '0;
        endcase
        if (panel_phase == PANEL_ARMED && (it.alarm_word[15:0] & mask) != '0 &&
            it.alarm_word[7:0] == panel_cfg.system_id) begin
          panel_remaining = panel_cfg.entry_delays[{panel_target, 3'b000} +: 8];
          panel_elapsed = '0;
          panel_phase = PANEL_ENTRY;
        end
      end
      REQ_MODE: begin
        if (it.new_mode != panel_target) begin
          panel_target = it.new_mode;
          panel_remaining = panel_cfg.exit_delays[{it.new_mode, 3'b000} +: 8];
          panel_elapsed = '0;
          panel_phase = PANEL_EXIT;
        end
      end
      default: ;
    endcase

    case (panel_phase)
      PANEL_EXIT:   status = ST_EXIT;
      PANEL_ENTRY:  status = ST_ENTRY;
      PANEL_ALARM:  status = ST_ALARM;
      PANEL_ARMED:  status = {2'b00, panel_target};
      PANEL_ARMING: status = (panel_target == MODE_DISARMED) ? ST_DISARMED :
                             ST_ALARM + {2'b00, panel_target};
      default:      status = ST_DISARMED;
    endcase
    r.panel_status = status;
    r.seconds_remaining = (panel_phase == PANEL_EXIT || panel_phase == PANEL_ENTRY) ?
                          panel_remaining : 8'd0;
    r.status_changed = (status != panel_last_status);
    panel_last_status = status;
    status_q.insert(status_q.size(), r);
  endfunction

  // Sender gap: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request item and hold it until taken; called and returns at a falling edge
  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req_type;
    s_tdata  <= {6'b0, it.new_mode, it.alarm_word};
    do @(posedge clk); while (!s_tready);
    advance_panel(it);
    @(negedge clk);
  endtask

  task automatic send_req(input logic [1:0] req, input logic [31:0] word, input logic [1:0] mode);
    item_t it;
    it.req_type = req;
    it.alarm_word = word;
    it.new_mode = mode;
    send_item(it);
  endtask

  // Drop valid and wait for every queued status item to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_config(input logic [7:0] sys_id, input logic [31:0] exits,
                             input logic [31:0] entries, input logic [23:0] trigs,
                             input logic [15:0] m_stay, input logic [15:0] m_night,
                             input logic [15:0] m_away);
    // upper bits carry noise that the register must drop
    write_reg(CFG_SYSTEM_ID, {24'($urandom_range(0, 32'hFF_FFFF)), sys_id});
    write_reg(CFG_EXIT_DELAYS, exits);
    write_reg(CFG_ENTRY_DELAYS, entries);
    write_reg(CFG_TRIG_DURATIONS, {8'($urandom_range(0, 255)), trigs});
    write_reg(CFG_MASK_STAY, {16'($urandom_range(0, 16'hFFFF)), m_stay});
    write_reg(CFG_MASK_NIGHT, {16'($urandom_range(0, 16'hFFFF)), m_night});
    write_reg(CFG_MASK_AWAY, {16'($urandom_range(0, 16'hFFFF)), m_away});
    write_reg(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] short_delays();
    return {8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
            8'($urandom_range(0, 7)), 8'($urandom_range(0, 7))};
  endfunction

  // Requests that must leave a disarmed panel alone
  task automatic test_idle_requests();
    send_req(REQ_TICK, 32'h0, MODE_STAY);
    send_req(REQ_ALARM, 32'hFFFF_FF01, MODE_AWAY);
    send_req(REQ_UNUSED, 32'hFFFF_FFFF, MODE_AWAY);
    send_req(REQ_MODE, 32'h0, MODE_DISARMED);
  endtask

  // Stay: exit, arming, armed, rejected alarms, zero entry delay, alarm, rearm, disarm
  task automatic test_stay_cycle();
    send_req(REQ_MODE, 32'h0, MODE_STAY);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_ALARM, 32'h0000_0000, MODE_DISARMED);
    send_req(REQ_ALARM, 32'h00FF_0001, MODE_DISARMED);
    send_req(REQ_ALARM, 32'h8000_0101, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_MODE, 32'h0, MODE_AWAY);
    send_req(REQ_MODE, 32'h0, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
  endtask

  // Night: longer exit, entry on a word of ones above the id byte, zero trigger duration
  task automatic test_night_cycle();
    send_req(REQ_MODE, 32'h0, MODE_NIGHT);
    repeat (3) send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_ALARM, 32'hFFFF_FF01, MODE_NIGHT);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
    send_req(REQ_TICK, 32'h0, MODE_DISARMED);
  endtask

  // Random requests over several register settings, extremes among them
  task automatic test_random_phases();
    item_t it;
    int    r;
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: load_config(8'h00, 32'h0, 32'h0, 24'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_config(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF,
                       16'h0, 16'hFFFF, 16'h0);
        default: load_config(8'($urandom_range(0, 255)), short_delays(), short_delays(),
                             24'(short_delays()), 16'($urandom), 16'($urandom),
                             16'($urandom));
      endcase
      for (int n = 0; n < 150; n++) begin
        // switch idling on and off in stretches
        if (n % 50 == 0) begin
          tx_gaps_on = $urandom_range(0, 2) != 0;
          rx_stalls_on = $urandom_range(0, 2) != 0;
        end
        it.alarm_word = $urandom;
        it.new_mode = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 55) begin
          it.req_type = REQ_TICK;
        end else if (r < 77) begin
          it.req_type = REQ_ALARM;
          if ($urandom_range(0, 3) != 0) it.alarm_word[7:0] = panel_cfg.system_id;
        end else if (r < 94) begin
          it.req_type = REQ_MODE;
        end else begin
          it.req_type = REQ_UNUSED;
        end
        send_item(it);
      end
    end
  endtask

  // Output stalls: mostly ready, some short stalls, a few long ones
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
      rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each status item with the oldest prediction
  always @(posedge clk) begin : status_check
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.panel_status      = m_tdata[3:0];
      got.seconds_remaining = m_tdata[11:4];
      got.status_changed    = m_tdata[12];
      if (status_q.size() == 0) begin
        $error("unexpected status item %h", m_tdata);
        error_count++;
      end else begin
        want = status_q.pop_front();
        if (got.panel_status !== want.panel_status) begin
          $error("panel_status: expected %0d, got %0d", want.panel_status, got.panel_status);
          error_count++;
        end
        if (got.seconds_remaining !== want.seconds_remaining) begin
          $error("seconds_remaining: expected %0d, got %0d",
                 want.seconds_remaining, got.seconds_remaining);
          error_count++;
        end
        if (got.status_changed !== want.status_changed) begin
          $error("status_changed: expected %0d, got %0d",
                 want.status_changed, got.status_changed);
          error_count++;
        end
      end
    end
  end

  initial begin
    panel_cfg.system_id         = RST_SYSTEM_ID;
    panel_cfg.exit_delays       = RST_EXIT_DELAYS;
    panel_cfg.entry_delays      = RST_ENTRY_DELAYS;
    panel_cfg.trigger_durations = RST_TRIG_DURATIONS;
    panel_cfg.arm_mask_stay     = RST_ARM_MASK;
    panel_cfg.arm_mask_night    = RST_ARM_MASK;
    panel_cfg.arm_mask_away     = RST_ARM_MASK;
    panel_phase       = PANEL_DISARMED;
    panel_target      = MODE_DISARMED;
    panel_elapsed     = '0;
    panel_remaining   = '0;
    panel_last_status = ST_DISARMED;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_idle_requests();
    drain();
    // short delays per mode; stay entry and night trigger are zero
    load_config(RST_SYSTEM_ID, 32'h0302_0100, 32'h0201_0000, 24'h01_0002,
                RST_ARM_MASK, RST_ARM_MASK, RST_ARM_MASK);
    test_stay_cycle();
    test_night_cycle();
    test_random_phases();
    drain();
    repeat (20) @(negedge clk);

    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
